// File: hw/rtl/cpfb_pkg.sv
package cpfb_pkg;

  localparam int BUFFER_BYTES = 3072;
  localparam int HDR_BYTES    = 22;
  localparam int HDR_CRC_SPAN = 20;
  localparam int CRC_BYTES    = 2;
  localparam int FIT_LIMIT    = BUFFER_BYTES - HDR_BYTES - CRC_BYTES;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'h1021;
  localparam logic [7:0]  SYNC_F   = 8'h46;
  localparam logic [7:0]  SYNC_T   = 8'h54;
  localparam logic [7:0]  VERSION_RESET = 8'd2;

  localparam int CFG_AW = 3;
  localparam logic [CFG_AW-1:0] ADDR_FRAME_VERSION = 3'd0;

  typedef enum logic {
    OP_START   = 1'b0,
    OP_PAYLOAD = 1'b1
  } op_t;

  function automatic logic [15:0] crc_add(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

endpackage

// File: hw/rtl/crc_protected_frame_builder_top.sv
// Frame builder for CRC-protected sensor frames. A start transaction emits a 22-byte
// little-endian header that closes with its own CRC-16, followed at once by the payload CRC
// when the stated payload length is zero; each payload transaction emits its byte, and the
// last one also emits the payload CRC low byte first. The output port carries one byte per
// cycle while out_stall is low; a start holds the input side until its header (and, at zero
// length, the payload CRC) is out, the last payload byte until its CRC is out, and other
// payload bytes flow at that rate. The item being sent sits in a job register before the
// output register; the next transaction is taken in the cycle its last byte moves out. Frames
// too large for the buffer are dropped unsent; payload bytes with no open frame are ignored.
module crc_protected_frame_builder_top #(
  parameter int BUFFER_BYTES = cpfb_pkg::BUFFER_BYTES
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_operation,
  input  logic [7:0]  in_flag_byte,
  input  logic [7:0]  in_map_rows,
  input  logic [7:0]  in_map_cols,
  input  logic [15:0] in_payload_length,
  input  logic [31:0] in_frame_period,
  input  logic [15:0] in_die_temperature,
  input  logic [15:0] in_rail_voltage,
  input  logic [7:0]  in_contact_count,
  input  logic [7:0]  in_rejected_count,
  input  logic [7:0]  in_payload_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_out_byte,
  output logic        out_run_end,
  output logic        out_frame_end,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [cpfb_pkg::CFG_AW-1:0] cfg_paddr,
  input  logic [31:0]                 cfg_pwdata,
  output logic [31:0]                 cfg_prdata,
  output logic                        cfg_pready
);
  import cpfb_pkg::*;

  localparam int FIT_BYTES = BUFFER_BYTES - HDR_BYTES - CRC_BYTES;

  logic [7:0]  version_r;
  logic [15:0] seq_r,    seq_nxt;
  logic [15:0] crc_r,    crc_nxt;
  logic [15:0] remain_r, remain_nxt;
  logic        open_r,   open_nxt;

  logic        job_valid_r, job_valid_nxt;
  logic [4:0]  job_idx_r,   job_idx_nxt;
  logic [4:0]  job_last_r,  job_last_nxt;
  logic        job_op_r;
  logic [7:0]  job_flag_r, job_rows_r, job_cols_r, job_contact_r, job_reject_r, job_byte_r;
  logic [15:0] job_len_r, job_temp_r, job_rail_r, job_seq_r, job_crc_r, job_crc_nxt;
  logic [31:0] job_period_r;
  logic [15:0] hcrc_r, hcrc_nxt;

  logic        out_valid_r, out_valid_nxt;
  logic [7:0]  out_byte_r, out_byte_nxt;
  logic        out_run_end_r, out_run_end_nxt;
  logic        out_frame_end_r, out_frame_end_nxt;

  logic        in_accept, move, job_at_last, fits, load, cfg_write;
  logic [15:0] pay_crc, remain_dec;
  logic [7:0]  hdr [HDR_CRC_SPAN];
  logic [7:0]  job_out_byte;
  logic        job_out_fend;

  assign cfg_pready = 1'b1;
  assign cfg_write  = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_prdata = (cfg_paddr == ADDR_FRAME_VERSION) ? {24'd0, version_r} : 32'd0;

  assign move        = job_valid_r && (!out_valid_r || !out_stall);
  assign job_at_last = (job_idx_r == job_last_r);
  assign in_stall    = job_valid_r && !(move && job_at_last);
  assign in_accept   = in_valid && !in_stall;

  assign fits       = ({1'b0, in_payload_length} <= 17'(FIT_BYTES));
  assign pay_crc    = crc_add(crc_r, in_payload_byte);
  assign remain_dec = remain_r - 16'd1;

  // Architectural frame state advances when the transaction is taken; the job stage keeps
  // the values needed to send its bytes.
  always_comb begin
    seq_nxt       = seq_r;
    crc_nxt       = crc_r;
    remain_nxt    = remain_r;
    open_nxt      = open_r;
    load          = 1'b0;
    job_last_nxt  = job_last_r;
    job_crc_nxt   = job_crc_r;
    if (in_accept) begin
      if (in_operation == OP_START) begin
        open_nxt   = 1'b0;
        remain_nxt = 16'd0;
        crc_nxt    = CRC_INIT;
        if (fits) begin
          load        = 1'b1;
          job_crc_nxt = CRC_INIT;
          if (in_payload_length == 16'd0) begin
            seq_nxt      = seq_r + 16'd1;
            job_last_nxt = 5'(HDR_BYTES + CRC_BYTES - 1);
          end else begin
            open_nxt     = 1'b1;
            remain_nxt   = in_payload_length;
            job_last_nxt = 5'(HDR_BYTES - 1);
          end
        end
      end else if (open_r) begin
        load        = 1'b1;
        job_crc_nxt = pay_crc;
        if (remain_dec == 16'd0) begin
          seq_nxt      = seq_r + 16'd1;
          open_nxt     = 1'b0;
          remain_nxt   = 16'd0;
          crc_nxt      = CRC_INIT;
          job_last_nxt = 5'(CRC_BYTES);
        end else begin
          remain_nxt   = remain_dec;
          crc_nxt      = pay_crc;
          job_last_nxt = 5'd0;
        end
      end
    end
  end

  always_comb begin
    hdr[0]  = SYNC_F;
    hdr[1]  = SYNC_T;
    hdr[2]  = version_r;
    hdr[3]  = job_flag_r;
    hdr[4]  = job_seq_r[7:0];
    hdr[5]  = job_seq_r[15:8];
    hdr[6]  = job_rows_r;
    hdr[7]  = job_cols_r;
    hdr[8]  = job_len_r[7:0];
    hdr[9]  = job_len_r[15:8];
    hdr[10] = job_period_r[7:0];
    hdr[11] = job_period_r[15:8];
    hdr[12] = job_period_r[23:16];
    hdr[13] = job_period_r[31:24];
    hdr[14] = job_temp_r[7:0];
    hdr[15] = job_temp_r[15:8];
    hdr[16] = job_rail_r[7:0];
    hdr[17] = job_rail_r[15:8];
    hdr[18] = job_contact_r;
    hdr[19] = job_reject_r;
  end

  // When a job carries the closing payload CRC, it is the last two bytes of that job.
  always_comb begin
    job_out_fend = 1'b0;
    job_out_byte = job_byte_r;
    if (job_at_last && (job_op_r == OP_PAYLOAD ? job_idx_r != 5'd0
                                               : job_last_r != 5'(HDR_BYTES - 1))) begin
      job_out_byte = job_crc_r[15:8];
      job_out_fend = 1'b1;
    end else if (job_idx_r == job_last_r - 5'd1 &&
                 (job_op_r == OP_PAYLOAD || job_last_r != 5'(HDR_BYTES - 1))) begin
      job_out_byte = job_crc_r[7:0];
    end else if (job_op_r == OP_START) begin
      if (job_idx_r < 5'(HDR_CRC_SPAN)) begin
        job_out_byte = hdr[job_idx_r];
      end else if (job_idx_r == 5'(HDR_CRC_SPAN)) begin
        job_out_byte = hcrc_r[7:0];
      end else begin
        job_out_byte = hcrc_r[15:8];
      end
    end
  end

  always_comb begin
    job_valid_nxt = job_valid_r;
    job_idx_nxt   = job_idx_r;
    hcrc_nxt      = hcrc_r;
    if (move) begin
      job_idx_nxt = job_idx_r + 5'd1;
      if (job_at_last) begin
        job_valid_nxt = 1'b0;
      end
      if (job_op_r == OP_START && job_idx_r < 5'(HDR_CRC_SPAN)) begin
        hcrc_nxt = crc_add(hcrc_r, job_out_byte);
      end
    end
    if (load) begin
      job_valid_nxt = 1'b1;
      job_idx_nxt   = 5'd0;
      hcrc_nxt      = CRC_INIT;
    end
  end

  always_comb begin
    out_valid_nxt     = out_valid_r;
    out_byte_nxt      = out_byte_r;
    out_run_end_nxt   = out_run_end_r;
    out_frame_end_nxt = out_frame_end_r;
    if (move) begin
      out_valid_nxt     = 1'b1;
      out_byte_nxt      = job_out_byte;
      out_run_end_nxt   = job_at_last;
      out_frame_end_nxt = job_out_fend;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      version_r   <= VERSION_RESET;
      seq_r       <= 16'd0;
      crc_r       <= CRC_INIT;
      remain_r    <= 16'd0;
      open_r      <= 1'b0;
      job_valid_r <= 1'b0;
      job_idx_r   <= 5'd0;
      job_last_r  <= 5'd0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_write && cfg_paddr == ADDR_FRAME_VERSION) begin
        version_r <= cfg_pwdata[7:0];
      end
      seq_r       <= seq_nxt;
      crc_r       <= crc_nxt;
      remain_r    <= remain_nxt;
      open_r      <= open_nxt;
      job_valid_r <= job_valid_nxt;
      job_idx_r   <= job_idx_nxt;
      job_last_r  <= job_last_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hcrc_r          <= hcrc_nxt;
    out_byte_r      <= out_byte_nxt;
    out_run_end_r   <= out_run_end_nxt;
    out_frame_end_r <= out_frame_end_nxt;
    if (load) begin
      job_op_r      <= in_operation;
      job_flag_r    <= in_flag_byte;
      job_rows_r    <= in_map_rows;
      job_cols_r    <= in_map_cols;
      job_len_r     <= in_payload_length;
      job_period_r  <= in_frame_period;
      job_temp_r    <= in_die_temperature;
      job_rail_r    <= in_rail_voltage;
      job_contact_r <= in_contact_count;
      job_reject_r  <= in_rejected_count;
      job_byte_r    <= in_payload_byte;
      job_seq_r     <= seq_r;
      job_crc_r     <= job_crc_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_out_byte  = out_byte_r;
  assign out_run_end   = out_run_end_r;
  assign out_frame_end = out_frame_end_r;

  a_job_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    job_valid_r |-> job_idx_r <= job_last_r)
    else $error("job byte index ran past the last byte");

  a_frame_end_is_run_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_frame_end_r) |-> out_run_end_r)
    else $error("frame end without end of transaction results");

  a_open_has_bytes: assert property (@(posedge clk) disable iff (!rst_n)
    open_r |-> remain_r != 16'd0)
    else $error("open frame with no payload bytes remaining");

  a_accept_only_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && job_valid_r) |-> (move && job_at_last))
    else $error("transaction taken while the job stage still had bytes to send");

endmodule

// File: tb/tb_crc_protected_frame_builder_top.sv
`timescale 1ns / 1ps

module tb_crc_protected_frame_builder_top;
  import cpfb_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE_CYCLES = 32;
  localparam int ITEMS_PER_PHASE = 150;
  localparam int MAX_PRINTS = 40;
  localparam int DRAIN_LIMIT = 50000;
  localparam logic [CFG_AW-1:0] ADDR_UNUSED = 3'd4;

  typedef struct {
    op_t         op;
    logic [7:0]  flags;
    logic [7:0]  rows;
    logic [7:0]  cols;
    logic [15:0] len;
    logic [31:0] period;
    logic [15:0] temp;
    logic [15:0] rail;
    logic [7:0]  contacts;
    logic [7:0]  rejects;
    logic [7:0]  data;
  } frame_item_t;

  typedef struct packed {
    logic [7:0] data;
    logic       run_end;
    logic       frame_end;
  } wire_byte_t;

  typedef enum {CHECK_MODEL, CHECK_NONE, CHECK_ECHO} check_kind_t;

  typedef struct {
    frame_item_t it;
    check_kind_t chk;
  } stim_row_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic        in_operation;
  logic [7:0]  in_flag_byte;
  logic [7:0]  in_map_rows;
  logic [7:0]  in_map_cols;
  logic [15:0] in_payload_length;
  logic [31:0] in_frame_period;
  logic [15:0] in_die_temperature;
  logic [15:0] in_rail_voltage;
  logic [7:0]  in_contact_count;
  logic [7:0]  in_rejected_count;
  logic [7:0]  in_payload_byte;
  logic        out_valid;
  logic        out_stall;
  logic [7:0]  out_out_byte;
  logic        out_run_end;
  logic        out_frame_end;
  logic              cfg_psel;
  logic              cfg_penable;
  logic              cfg_pwrite;
  logic [CFG_AW-1:0] cfg_paddr;
  logic [31:0]       cfg_pwdata;
  logic [31:0]       cfg_prdata;
  logic              cfg_pready;

  wire_byte_t  pending_bytes[$];
  wire_byte_t  fresh_bytes[$];
  stim_row_t   directed_rows[$];

  logic [7:0]  cur_version;
  logic [15:0] seq_num;
  logic [15:0] run_crc;
  logic [15:0] bytes_left;
  logic        frame_live;

  int mismatches;
  int cycle_count;
  int items_done;
  int send_idle_pct;
  int recv_stall_pct;

  crc_protected_frame_builder_top uut (.*);

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_crc_protected_frame_builder_top failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_stall <= rst_n && ($urandom_range(0, 99) < recv_stall_pct);
  end

  task automatic note_mismatch(input string what, input int got, input int want);
    mismatches++;
    if (mismatches <= MAX_PRINTS) begin
      $display("mismatch: %s at cycle %0d, got %0h, expected %0h", what, cycle_count, got, want);
    end
  endtask

  always @(posedge clk) begin
    wire_byte_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_bytes.size() == 0) begin
        note_mismatch("transaction with nothing expected, out_byte", out_out_byte, 0);
      end else begin
        want = pending_bytes.pop_front();
        if (out_out_byte !== want.data) note_mismatch("out_byte", out_out_byte, want.data);
        if (out_run_end !== want.run_end) note_mismatch("run_end", out_run_end, want.run_end);
        if (out_frame_end !== want.frame_end) begin
          note_mismatch("frame_end", out_frame_end, want.frame_end);
        end
      end
    end
  end

  function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    logic        fb;
    int          i;
    c = crc;
    for (i = 7; i >= 0; i--) begin
      fb = c[15] ^ b[i];
      c = {c[14:0], 1'b0};
      if (fb) c = c ^ CRC_POLY;
    end
    return c;
  endfunction

  function automatic void push_byte(input logic [7:0] b, input logic fend);
    wire_byte_t w;
    w.data = b;
    w.run_end = 1'b0;
    w.frame_end = fend;
    fresh_bytes.push_back(w);
  endfunction

  function automatic void close_frame();
    push_byte(run_crc[7:0], 1'b0);
    push_byte(run_crc[15:8], 1'b1);
    seq_num = seq_num + 16'd1;
    frame_live = 1'b0;
    bytes_left = '0;
    run_crc = CRC_INIT;
  endfunction

  function automatic void build_frame_bytes(input frame_item_t it);
    logic [7:0]  hdr [0:HDR_BYTES-1];
    logic [15:0] hc;
    wire_byte_t  last;
    int          i;
    fresh_bytes.delete();
    if (it.op == OP_START) begin
      frame_live = 1'b0;
      bytes_left = '0;
      run_crc = CRC_INIT;
      if (HDR_BYTES + CRC_BYTES + int'(it.len) <= BUFFER_BYTES) begin
        hdr[0] = SYNC_F;
        hdr[1] = SYNC_T;
        hdr[2] = cur_version;
        hdr[3] = it.flags;
        hdr[4] = seq_num[7:0];
        hdr[5] = seq_num[15:8];
        hdr[6] = it.rows;
        hdr[7] = it.cols;
        hdr[8] = it.len[7:0];
        hdr[9] = it.len[15:8];
        hdr[10] = it.period[7:0];
        hdr[11] = it.period[15:8];
        hdr[12] = it.period[23:16];
        hdr[13] = it.period[31:24];
        hdr[14] = it.temp[7:0];
        hdr[15] = it.temp[15:8];
        hdr[16] = it.rail[7:0];
        hdr[17] = it.rail[15:8];
        hdr[18] = it.contacts;
        hdr[19] = it.rejects;
        hc = CRC_INIT;
        for (i = 0; i < HDR_CRC_SPAN; i++) hc = crc16_step(hc, hdr[i]);
        hdr[20] = hc[7:0];
        hdr[21] = hc[15:8];
        for (i = 0; i < HDR_BYTES; i++) push_byte(hdr[i], 1'b0);
        if (it.len == 16'd0) begin
          close_frame();
        end else begin
          frame_live = 1'b1;
          bytes_left = it.len;
        end
      end
    end else if (frame_live) begin
      push_byte(it.data, 1'b0);
      run_crc = crc16_step(run_crc, it.data);
      bytes_left = bytes_left - 16'd1;
      if (bytes_left == 16'd0) close_frame();
    end
    if (fresh_bytes.size() > 0) begin
      last = fresh_bytes.pop_back();
      last.run_end = 1'b1;
      fresh_bytes.push_back(last);
    end
  endfunction

  function automatic frame_item_t start_item(input logic [15:0] len, input logic [7:0] fill);
    frame_item_t it;
    it.op = OP_START;
    it.flags = fill;
    it.rows = fill;
    it.cols = fill;
    it.len = len;
    it.period = {4{fill}};
    it.temp = {2{fill}};
    it.rail = {2{fill}};
    it.contacts = fill;
    it.rejects = fill;
    it.data = fill;
    return it;
  endfunction

  function automatic frame_item_t random_start(input logic [15:0] len);
    frame_item_t it;
    it.op = OP_START;
    it.flags = 8'($urandom);
    it.rows = 8'($urandom);
    it.cols = 8'($urandom);
    it.len = len;
    it.period = $urandom;
    it.temp = 16'($urandom);
    it.rail = 16'($urandom);
    it.contacts = 8'($urandom);
    it.rejects = 8'($urandom);
    it.data = 8'($urandom);
    return it;
  endfunction

  function automatic frame_item_t payload_item(input logic [7:0] b);
    frame_item_t it;
    it = random_start(16'($urandom));
    it.op = OP_PAYLOAD;
    it.data = b;
    return it;
  endfunction

  task automatic send_item(input frame_item_t it, input check_kind_t chk);
    wire_byte_t echo;
    int         i;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_operation <= it.op;
    in_flag_byte <= it.flags;
    in_map_rows <= it.rows;
    in_map_cols <= it.cols;
    in_payload_length <= it.len;
    in_frame_period <= it.period;
    in_die_temperature <= it.temp;
    in_rail_voltage <= it.rail;
    in_contact_count <= it.contacts;
    in_rejected_count <= it.rejects;
    in_payload_byte <= it.data;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (it.op == OP_START || frame_live) items_done++;
    build_frame_bytes(it);
    case (chk)
      CHECK_MODEL: begin
        for (i = 0; i < fresh_bytes.size(); i++) pending_bytes.push_back(fresh_bytes[i]);
      end
      CHECK_ECHO: begin
        echo.data = it.data;
        echo.run_end = 1'b1;
        echo.frame_end = 1'b0;
        pending_bytes.push_back(echo);
      end
      default: begin
      end
    endcase
  endtask

  task automatic settle(input int extra);
    int waited;
    waited = 0;
    in_valid <= 1'b0;
    while (pending_bytes.size() > 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (pending_bytes.size() > 0) begin
      note_mismatch("results never delivered, count", pending_bytes.size(), 0);
      pending_bytes.delete();
    end
    repeat (extra) @(posedge clk);
  endtask

  task automatic write_register(input logic [CFG_AW-1:0] addr, input logic [7:0] val);
    logic [31:0] word;
    word = $urandom;
    word[7:0] = val;
    settle(SETTLE_CYCLES);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= addr;
    cfg_pwdata <= word;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    if (addr == ADDR_FRAME_VERSION) cur_version = val;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    cfg_paddr <= ADDR_FRAME_VERSION;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    if (cfg_prdata[7:0] !== cur_version) begin
      note_mismatch("frame_version readback", cfg_prdata[7:0], cur_version);
    end
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  initial begin
    int phase;
    int phase_base;
    int r;
    int len;
    int cut;
    int k;
    logic [7:0] ver;

    mismatches = 0;
    cycle_count = 0;
    items_done = 0;
    send_idle_pct = 22;
    recv_stall_pct = 80;
    cur_version = VERSION_RESET;
    seq_num = '0;
    run_crc = CRC_INIT;
    bytes_left = '0;
    frame_live = 1'b0;
    out_stall = 1'b0;

    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_operation <= OP_START;
    in_flag_byte <= '0;
    in_map_rows <= '0;
    in_map_cols <= '0;
    in_payload_length <= '0;
    in_frame_period <= '0;
    in_die_temperature <= '0;
    in_rail_voltage <= '0;
    in_contact_count <= '0;
    in_rejected_count <= '0;
    in_payload_byte <= '0;
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    cfg_paddr <= ADDR_FRAME_VERSION;
    cfg_pwdata <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Stray byte, empty payloads at both extremes, the buffer boundary, an
    // abandoned frame, a normal close, and an oversize start that drops an open frame.
    directed_rows.push_back('{payload_item(8'hFF), CHECK_NONE});
    directed_rows.push_back('{start_item(16'd0, 8'h00), CHECK_MODEL});
    directed_rows.push_back('{start_item(16'd0, 8'hFF), CHECK_MODEL});
    directed_rows.push_back('{start_item(16'hFFFF, 8'hFF), CHECK_NONE});
    directed_rows.push_back('{start_item(16'(FIT_LIMIT + 1), 8'h00), CHECK_NONE});
    directed_rows.push_back('{start_item(16'(FIT_LIMIT), 8'hFF), CHECK_MODEL});
    directed_rows.push_back('{payload_item(8'h00), CHECK_ECHO});
    directed_rows.push_back('{payload_item(8'hFF), CHECK_ECHO});
    directed_rows.push_back('{start_item(16'd3, 8'h5A), CHECK_MODEL});
    directed_rows.push_back('{payload_item(8'hA5), CHECK_ECHO});
    directed_rows.push_back('{payload_item(8'h5A), CHECK_ECHO});
    directed_rows.push_back('{payload_item(8'h3C), CHECK_MODEL});
    directed_rows.push_back('{payload_item(8'h77), CHECK_NONE});
    directed_rows.push_back('{start_item(16'd1, 8'hA5), CHECK_MODEL});
    directed_rows.push_back('{payload_item(8'h00), CHECK_MODEL});
    directed_rows.push_back('{start_item(16'd2, 8'h00), CHECK_MODEL});
    directed_rows.push_back('{payload_item(8'h11), CHECK_ECHO});
    directed_rows.push_back('{start_item(16'd40000, 8'h00), CHECK_NONE});
    directed_rows.push_back('{payload_item(8'h22), CHECK_NONE});
    foreach (directed_rows[i]) send_item(directed_rows[i].it, directed_rows[i].chk);

    for (phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 22;
          recv_stall_pct = 80;
          ver = 8'hFF;
          write_register(ADDR_UNUSED, 8'($urandom));
        end
        1: begin
          send_idle_pct = 80;
          recv_stall_pct = 22;
          ver = 8'h00;
        end
        default: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
          ver = 8'($urandom);
        end
      endcase
      write_register(ADDR_FRAME_VERSION, ver);
      phase_base = items_done;
      while (items_done - phase_base < ITEMS_PER_PHASE) begin
        r = $urandom_range(0, 99);
        if (r < 3) begin
          settle(0);
        end else if (r < 82) begin
          if ($urandom_range(0, 9) == 0) len = 0;
          else if ($urandom_range(0, 19) == 0) len = $urandom_range(25, 160);
          else len = $urandom_range(1, 24);
          cut = len;
          if (r >= 75 && len > 0) cut = $urandom_range(0, len - 1);
          send_item(random_start(16'(len)), CHECK_MODEL);
          for (k = 0; k < cut; k++) send_item(payload_item(8'($urandom)), CHECK_MODEL);
        end else if (r < 90) begin
          send_item(random_start(16'($urandom_range(FIT_LIMIT + 1, 65535))), CHECK_MODEL);
        end else begin
          send_item(payload_item(8'($urandom)), CHECK_MODEL);
        end
      end
    end

    settle(SETTLE_CYCLES);
    if (mismatches == 0) begin
      $display("tb_crc_protected_frame_builder_top passed");
    end else begin
      $display("tb_crc_protected_frame_builder_top failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/cpfb_pkg.sv
hw/rtl/crc_protected_frame_builder_top.sv
tb/tb_crc_protected_frame_builder_top.sv
